>>> rtl/lcs_pkg.sv
// Shared types and constants for the LCS length engine.
// Used by lcs_cell, lcs_length_engine_core and the bench; no other dependencies.
package lcs_pkg;

    localparam int MAX_LEN = 64;
    localparam int DP_W    = $clog2(MAX_LEN + 1);
    localparam int LEN_W   = 7;
    localparam int SYM_W   = 8;
    localparam int KIND_W  = 2;
    localparam int SAT_W   = (DP_W > LEN_W) ? DP_W : LEN_W;

    localparam logic [LEN_W-1:0]  LEN_MAX  = {LEN_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_A      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_B      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // One beat travelling down the cell chain.
    // For a B beat, left/diag carry the wavefront values; for an end beat,
    // left carries the length picked up from the last filled cell.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  sym;
        logic [DP_W-1:0]   left;
        logic [DP_W-1:0]   diag;
        logic              claimed;
    } t_tok;

endpackage

>>> rtl/lcs_length_engine_core.sv
// LCS length engine: a row of MAX_LEN cells, one per symbol of string A.
// An accepted end beat passes every cell register and then the result register before its result beat.
// Throughput: one input beat per cycle; the whole row halts while a result is stalled.
// Every beat walks the row in order, so appends, B symbols and ends never overtake.
// Reset (synchronous, active low) empties the row and clears the overflow flag at once.
// Depends on lcs_pkg and lcs_cell.
module lcs_length_engine_core
    import lcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [SYM_W-1:0]  i_symbol,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [LEN_W-1:0]  o_lcs_length,
    output logic              o_a_overflow
);

    logic                    adv;
    logic [MAX_LEN:0]        chain_vld;
    t_tok                    chain_tok [MAX_LEN+1];
    logic                    r_ovf;
    logic                    n_ovf;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic [LEN_W-1:0]        r_len;
    logic [LEN_W-1:0]        n_len;
    logic                    r_out_ovf;
    logic                    n_out_ovf;
    logic [SAT_W-1:0]        end_len;
    t_tok                    tail;
    logic                    tail_vld;

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;

    // unused kind enters as a bubble
    assign chain_vld[0]          = i_in_valid && (i_kind != KIND_UNUSED);
    assign chain_tok[0].kind     = i_kind;
    assign chain_tok[0].sym      = i_symbol;
    assign chain_tok[0].left     = '0;
    assign chain_tok[0].diag     = '0;
    assign chain_tok[0].claimed  = 1'b0;

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        lcs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_vld   (chain_vld[g]),
            .i_tok   (chain_tok[g]),
            .o_vld   (chain_vld[g+1]),
            .o_tok   (chain_tok[g+1])
        );
    end

    assign tail     = chain_tok[MAX_LEN];
    assign tail_vld = chain_vld[MAX_LEN];
    assign end_len  = SAT_W'(tail.left);

    always_comb begin
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_out_stall;
        n_len       = r_len;
        n_out_ovf   = r_out_ovf;
        if (tail_vld && tail.kind == KIND_A && !tail.claimed) begin
            n_ovf = 1'b1;
        end
        if (tail_vld && tail.kind == KIND_END) begin
            n_out_valid = 1'b1;
            n_len       = (end_len > SAT_W'(LEN_MAX)) ? LEN_MAX : LEN_W'(end_len);
            n_out_ovf   = r_ovf;
            n_ovf       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_len     <= n_len;
            r_out_ovf <= n_out_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_lcs_length = r_len;
    assign o_a_overflow = r_out_ovf;

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && tail_vld && tail.kind == KIND_END) |=> o_out_valid)
        else $error("end beat at row tail produced no result");

    a_drop_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && tail_vld && tail.kind == KIND_A && !tail.claimed) |=> r_ovf)
        else $error("dropped append did not set overflow");

    a_end_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && tail_vld && tail.kind == KIND_END) |=> !r_ovf)
        else $error("overflow flag survived end of pair");

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (SAT_W'(o_lcs_length) <= SAT_W'(MAX_LEN)))
        else $error("reported length exceeds capacity");

endmodule

>>> rtl/lcs_cell.sv
// One systolic cell: holds one symbol of string A and its DP entry.
// Depends on lcs_pkg for the beat type and kind codes.
module lcs_cell
    import lcs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_adv,
    input  logic  i_vld,
    input  t_tok  i_tok,
    output logic  o_vld,
    output t_tok  o_tok
);

    logic             r_used;
    logic             n_used;
    logic [SYM_W-1:0] r_sym;
    logic [SYM_W-1:0] n_sym;
    logic [DP_W-1:0]  r_dp;
    logic [DP_W-1:0]  n_dp;
    logic             r_vld;
    t_tok             r_tok;
    t_tok             n_tok;
    logic [DP_W-1:0]  best;
    logic [DP_W-1:0]  diag_inc;

    always_comb begin
        n_used   = r_used;
        n_sym    = r_sym;
        n_dp     = r_dp;
        n_tok    = i_tok;
        diag_inc = i_tok.diag + DP_W'(1);
        best     = (r_dp > i_tok.left) ? r_dp : i_tok.left;
        if (r_sym == i_tok.sym && diag_inc > best) begin
            best = diag_inc;
        end
        if (i_vld) begin
            case (i_tok.kind)
                KIND_A: begin
                    // claim the first free cell
                    if (!i_tok.claimed && !r_used) begin
                        n_used        = 1'b1;
                        n_sym         = i_tok.sym;
                        n_dp          = '0;
                        n_tok.claimed = 1'b1;
                    end
                end
                KIND_B: begin
                    if (r_used) begin
                        n_dp       = best;
                        n_tok.left = best;
                        n_tok.diag = r_dp;
                    end
                end
                KIND_END: begin
                    if (r_used) begin
                        n_tok.left = r_dp;
                        n_used     = 1'b0;
                        n_dp       = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_dp   <= '0;
            r_vld  <= 1'b0;
        end else if (i_adv) begin
            r_used <= n_used;
            r_dp   <= n_dp;
            r_vld  <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sym <= n_sym;
            r_tok <= n_tok;
        end
    end

    assign o_vld = r_vld;
    assign o_tok = r_tok;

endmodule

>>> bench/lcs_length_engine_core_tb.sv
// Self-checking bench for lcs_length_engine_core: drives A appends, B symbols and pair ends,
// predicts each reported LCS length and overflow flag, and checks every result beat.
// Depends on lcs_pkg and the RTL of lcs_length_engine_core.
module lcs_length_engine_core_tb
    import lcs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             overflow;
    } t_lcs_report;

    // Tracks the stored string A and the DP row, and queues the report each pair end owes.
    class t_pair_tracker;
        logic [SYM_W-1:0] a_syms [MAX_LEN];
        int unsigned      row [MAX_LEN];
        int unsigned      a_cnt;
        logic             a_ovf;
        t_lcs_report      expected_reports [$];
        int               mismatches;

        function new();
            foreach (row[i]) begin
                row[i]     = 0;
                a_syms[i]  = '0;
            end
            a_cnt      = 0;
            a_ovf      = 1'b0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

        function void absorb_beat(logic [KIND_W-1:0] kind, logic [SYM_W-1:0] sym);
            int unsigned diag;
            int unsigned left;
            int unsigned up;
            int unsigned val;
            int unsigned len;
            t_lcs_report rep;
            case (kind)
                KIND_A: begin
                    if (a_cnt < MAX_LEN) begin
                        a_syms[a_cnt] = sym;
                        row[a_cnt]    = 0;
                        a_cnt++;
                    end else begin
                        a_ovf = 1'b1;
                    end
                end
                KIND_B: begin
                    diag = 0;
                    left = 0;
                    for (int i = 0; i < a_cnt; i++) begin
                        up  = row[i];
                        val = (up > left) ? up : left;
                        if (a_syms[i] == sym && diag + 1 > val)
                            val = diag + 1;
                        diag   = up;
                        left   = val;
                        row[i] = val;
                    end
                end
                KIND_END: begin
                    len = (a_cnt > 0) ? row[a_cnt - 1] : 0;
                    if (len > LEN_MAX)
                        len = LEN_MAX;
                    rep.length   = len[LEN_W-1:0];
                    rep.overflow = a_ovf;
                    expected_reports = {expected_reports, rep};
                    foreach (row[i])
                        row[i] = 0;
                    a_cnt = 0;
                    a_ovf = 1'b0;
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what, int got, int want);
            mismatches++;
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        endtask

        task check_report(logic [LEN_W-1:0] length, logic overflow);
            t_lcs_report want;
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected result beat, length", length, -1);
            end else begin
                want = expected_reports.pop_front();
                if (length !== want.length)
                    report_mismatch("lcs_length", length, want.length);
                if (overflow !== want.overflow)
                    report_mismatch("a_overflow", overflow, want.overflow);
            end
        endtask
    endclass

    localparam int                RANDOM_BEATS = 1200;
    localparam int                LONG_HOLD    = 400;
    localparam int                CYCLE_LIMIT  = 400000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic [KIND_W-1:0] in_kind   = KIND_A;
    logic [SYM_W-1:0]  in_symbol = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [LEN_W-1:0]  lcs_length;
    logic              a_overflow;

    t_pair_tracker   tracker = new();
    bit              tx_idle_on    = 1'b1;
    bit              rx_idle_on    = 1'b1;
    bit              long_hold_req = 1'b0;
    int              beats_counted = 0;
    int              cycle_count   = 0;

    lcs_length_engine_core u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_kind       (in_kind),
        .i_symbol     (in_symbol),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_lcs_length (lcs_length),
        .o_a_overflow (a_overflow)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one beat, after a random gap while tx idles are on, and hold it until the engine takes it.
    task automatic send_beat(logic [KIND_W-1:0] kind, logic [SYM_W-1:0] sym);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_kind   <= kind;
        in_symbol <= sym;
        do @(posedge clk); while (in_stall);
        tracker.absorb_beat(kind, sym);
        if (kind != KIND_UNUSED)
            beats_counted++;
    endtask

    // Drop valid and wait on clock edges until all owed results have drained.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.outstanding() != 0);
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol(logic [SYM_W-1:0] base, int alpha);
        if (alpha == 0)
            return SYM_W'($urandom_range(0, 255));
        return SYM_W'(base + $urandom_range(0, alpha - 1));
    endfunction

    task automatic send_pair(int a_len, int b_len, int alpha);
        logic [SYM_W-1:0] base;
        base = SYM_W'($urandom_range(0, 255));
        repeat (a_len) send_beat(KIND_A, pick_symbol(base, alpha));
        repeat (b_len) send_beat(KIND_B, pick_symbol(base, alpha));
        send_beat(KIND_END, SYM_W'($urandom_range(0, 255)));
    endtask

    task automatic random_pair();
        int               sel;
        int               n;
        int               k;
        int               alpha;
        logic [SYM_W-1:0] base;
        sel = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       alpha = 0;
            1:       alpha = 2;
            2:       alpha = 3;
            default: alpha = 4;
        endcase
        if (sel < 8) begin
            send_pair($urandom_range(56, 70), $urandom_range(40, 70), $urandom_range(1, 3));
        end else if (sel < 80) begin
            send_pair($urandom_range(0, 12), $urandom_range(0, 14), alpha);
        end else begin
            // mixed appends, B symbols and unused kinds; sometimes no end, so state carries over
            base = SYM_W'($urandom_range(0, 255));
            n    = $urandom_range(1, 24);
            repeat (n) begin
                k = $urandom_range(0, 9);
                if (k < 4)
                    send_beat(KIND_A, pick_symbol(base, alpha));
                else if (k < 8)
                    send_beat(KIND_B, pick_symbol(base, alpha));
                else
                    send_beat(KIND_UNUSED, SYM_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 4) != 0)
                send_beat(KIND_END, SYM_W'($urandom_range(0, 255)));
        end
    endtask

    // Result side: stall at random while rx idles are on, or long on request; then take the next one.
    initial begin : result_sink
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                hold = rx_idle_on ? $urandom_range(0, 14) : 0;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid && !long_hold_req);
            if (out_valid)
                tracker.check_report(lcs_length, a_overflow);
        end
    end

    initial begin : stimulus
        bit pressure_done;
        bit pause_done;
        int phase;
        pressure_done = 1'b0;
        pause_done    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // end on an empty pair, an unused kind, and a B symbol with no A stored
        send_beat(KIND_END, 8'hFF);
        send_beat(KIND_UNUSED, 8'hFF);
        send_beat(KIND_B, 8'hA5);
        send_beat(KIND_END, 8'h00);
        // symbol extremes on both strings
        send_beat(KIND_A, 8'h00);
        send_beat(KIND_A, 8'hFF);
        send_beat(KIND_B, 8'hFF);
        send_beat(KIND_UNUSED, 8'h00);
        send_beat(KIND_B, 8'h00);
        send_beat(KIND_B, 8'hFF);
        send_beat(KIND_END, 8'hFF);
        // A grows after B has begun
        send_beat(KIND_A, 8'h3C);
        send_beat(KIND_B, 8'h3C);
        send_beat(KIND_A, 8'h3C);
        send_beat(KIND_B, 8'h3C);
        send_beat(KIND_B, 8'hC3);
        send_beat(KIND_A, 8'hC3);
        send_beat(KIND_END, 8'h5A);
        // full row plus dropped symbols: longest possible length with the flag set
        send_pair(MAX_LEN + 2, MAX_LEN, 1);

        beats_counted = 0;
        while (beats_counted < RANDOM_BEATS) begin
            phase      = (beats_counted / 250) % 4;
            tx_idle_on = (phase == 0) || (phase == 2);
            rx_idle_on = (phase == 0) || (phase == 3);
            if (!pressure_done && beats_counted >= 500) begin
                // stall results for a long stretch while beats keep coming
                pressure_done = 1'b1;
                tx_idle_on    = 1'b0;
                long_hold_req = 1'b1;
                repeat (24) send_pair($urandom_range(2, 8), $urandom_range(2, 8), 3);
            end else if (!pause_done && beats_counted >= 950) begin
                pause_done = 1'b1;
                drain_results();
            end else begin
                random_pair();
            end
        end

        drain_results();
        repeat (MAX_LEN + 8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
